// ===== design/mra_pkg.sv =====
// Package for the minBLEP ring accumulator: field widths, default parameter
// values, command and sequencer codes, and the shared multiplier control type.
// No dependencies; every other design file imports it.
`timescale 1ns / 1ps
`default_nettype none

package mra_pkg;

  // Default sizes of the step table and correction ring.
  localparam int ZERO_CROSSINGS_DEF = 16;
  localparam int OVERSAMPLE_DEF     = 32;

  // Fixed payload widths.
  localparam int CMD_W    = 2;
  localparam int PHASE_W  = 18;
  localparam int AMP_W    = 16;
  localparam int TIDX_W   = 11;
  localparam int TWORD_W  = 18;
  localparam int SAMPLE_W = 32;

  // Internal datapath widths.
  localparam int FRAC_W = 16;                    // sub-sample fraction
  localparam int DIFF_W = TWORD_W + 1;           // difference of two table words
  localparam int PROD_W = DIFF_W + FRAC_W + 1;   // shared multiplier result
  localparam int ACC_W  = SAMPLE_W + 5;          // accumulator sum before saturation

  // Phase bounds of an accepted insert, in Q2.16.
  localparam logic signed [PHASE_W-1:0] PHASE_MIN_EXCL = -18'sd65536;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_LOAD   = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TICK_OUT,
    S_T0,
    S_T1,
    S_MF,
    S_MA,
    S_AC
  } state_t;

  typedef enum logic {
    MUL_INTERP,
    MUL_SCALE
  } mul_op_t;

  typedef struct packed {
    logic    en;
    mul_op_t op;
  } mul_ctl_t;

endpackage

`default_nettype wire

// ===== design/mra_channels.sv =====
// Valid/ready channel interfaces of the minBLEP ring accumulator:
// the command channel into the block and the sample channel out of it.
// Depends on mra_pkg for the payload widths.
`timescale 1ns / 1ps
`default_nettype none

interface mra_in_if;
  import mra_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [CMD_W-1:0]           command;
  logic signed [PHASE_W-1:0]  phase;
  logic signed [AMP_W-1:0]    amp;
  logic [TIDX_W-1:0]          table_index;
  logic signed [TWORD_W-1:0]  table_word;

  modport source (output valid, command, phase, amp, table_index, table_word,
                  input ready);
  modport sink (input valid, command, phase, amp, table_index, table_word,
                output ready);
endinterface

interface mra_out_if;
  import mra_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, sample, input ready);
  modport sink (input valid, sample, output ready);
endinterface

`default_nettype wire

// ===== design/minblep_ring_accumulator_core.sv =====
// MinBLEP correction engine: a ring of 2*ZERO_CROSSINGS saturating
// accumulators fed from a step table of 2*ZERO_CROSSINGS*OVERSAMPLE+1 words.
// Commands arrive on in_ch (valid/ready); a transfer takes place when both
// are high. A load writes one table word and finishes in the transfer cycle.
// An insert with phase in (-1,0] walks every ring slot from the read
// position on; each slot takes two table reads on the single table port and
// two passes through the one shared multiplier, so an insert occupies the
// block until its walk has ended. An insert with any other phase is
// dropped at once.
// A tick reads the slot at the read position, clears it and advances the
// position; its sample is loaded into the out_ch output register from state
// S_TICK_OUT once that register is free, and the block is then ready again.
// in_ch.ready is high only while the sequencer is idle. A stalled receiver
// holds the sample in the output register while later loads and inserts
// proceed; a further tick waits until the register has been emptied.
// Synchronous reset empties the ring (per-slot valid flags), zeroes the read
// position and drops any pending sample; the step table keeps its contents
// and must be loaded before the first insert.
`timescale 1ns / 1ps
`default_nettype none

module minblep_ring_accumulator_core #(
  parameter int ZERO_CROSSINGS = mra_pkg::ZERO_CROSSINGS_DEF,
  parameter int OVERSAMPLE     = mra_pkg::OVERSAMPLE_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  mra_in_if.sink    in_ch,
  mra_out_if.source out_ch
);
  import mra_pkg::*;

  localparam int RING_LEN  = 2 * ZERO_CROSSINGS;
  localparam int TABLE_LEN = 2 * ZERO_CROSSINGS * OVERSAMPLE + 1;
  localparam int RW        = $clog2(RING_LEN);
  localparam int TW        = $clog2(TABLE_LEN);
  localparam int OW        = $clog2(OVERSAMPLE);
  localparam int XW        = FRAC_W + OW;

  state_t state_r, state_nxt;

  // Storage.
  logic signed [TWORD_W-1:0]  tbl_mem [TABLE_LEN];
  logic signed [TWORD_W-1:0]  tbl_q;
  logic signed [SAMPLE_W-1:0] ring_mem [RING_LEN];
  logic signed [SAMPLE_W-1:0] ring_q;
  logic                       ring_vq;
  logic [RING_LEN-1:0]        ring_vld_r;

  // Walk registers.
  logic [RW-1:0]              rd_pos_r;
  logic [RW-1:0]              slot_r;
  logic [RW-1:0]              cnt_r;
  logic [TW-1:0]              tidx_r;
  logic [FRAC_W-1:0]          frac_r;
  logic signed [AMP_W-1:0]    amp_r;
  logic signed [TWORD_W-1:0]  t0_r;

  // Output register.
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;

  // Datapath signals.
  logic                       acc_tick;
  logic                       acc_insert;
  logic                       acc_load;
  logic                       phase_ok;
  logic signed [PHASE_W-1:0]  phase_neg;
  logic [XW-1:0]              phase_x;
  logic [RW-1:0]              slot_nxt;
  logic                       walk_last;
  logic                       out_free;

  logic                       tbl_re;
  logic [TW-1:0]              tbl_ra;
  logic                       ring_re;
  logic [RW-1:0]              ring_ra;
  logic                       ring_we;

  mul_ctl_t                   mul_ctl;
  logic signed [DIFF_W-1:0]   diff;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [PROD_W-FRAC_W-1:0] slope_part;
  logic signed [PROD_W-FRAC_W-1:0] interp_w;
  logic signed [TWORD_W-1:0]  interp;
  logic signed [SAMPLE_W-1:0] ring_cur;
  logic signed [ACC_W-1:0]    acc_sum;
  logic signed [SAMPLE_W-1:0] acc_sat;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.sample = out_sample_r;

  assign acc_tick   = in_ch.valid && in_ch.ready && (cmd_t'(in_ch.command) == CMD_TICK);
  assign acc_insert = in_ch.valid && in_ch.ready && (cmd_t'(in_ch.command) == CMD_INSERT);
  assign acc_load   = in_ch.valid && in_ch.ready && (cmd_t'(in_ch.command) == CMD_LOAD);

  assign phase_ok  = (in_ch.phase <= 0) && (in_ch.phase > PHASE_MIN_EXCL);
  assign phase_neg = -in_ch.phase;
  assign phase_x   = XW'(phase_neg[FRAC_W-1:0]) * XW'(OVERSAMPLE);

  assign slot_nxt  = (slot_r == RW'(RING_LEN - 1)) ? '0 : slot_r + 1'b1;
  assign walk_last = (cnt_r == RW'(RING_LEN - 1));
  assign out_free  = !out_valid_r || out_ch.ready;

  // Interpolation: t0 + floor((t1 - t0) * frac / 2^16).
  assign diff       = DIFF_W'(tbl_q) - DIFF_W'(t0_r);
  assign slope_part = prod_r[PROD_W-1:FRAC_W];
  assign interp_w   = (PROD_W - FRAC_W)'(t0_r) + slope_part;
  assign interp     = $signed(interp_w[TWORD_W-1:0]);

  // Saturating accumulate of the scaled correction into the current slot.
  assign ring_cur = ring_vq ? ring_q : '0;
  assign acc_sum  = ACC_W'(ring_cur) + ACC_W'(prod_r);
  always_comb begin
    if ((&acc_sum[ACC_W-1:SAMPLE_W-1]) || !(|acc_sum[ACC_W-1:SAMPLE_W-1])) begin
      acc_sat = acc_sum[SAMPLE_W-1:0];
    end else if (acc_sum[ACC_W-1]) begin
      acc_sat = {1'b1, {(SAMPLE_W - 1){1'b0}}};
    end else begin
      acc_sat = {1'b0, {(SAMPLE_W - 1){1'b1}}};
    end
  end

  mra_mul_unit u_mul (
    .clk    (clk),
    .ctl    (mul_ctl),
    .diff   (diff),
    .frac   (frac_r),
    .interp (interp),
    .amp    (amp_r),
    .prod_r (prod_r)
  );

  // Sequencer: next state and memory/multiplier controls.
  always_comb begin
    state_nxt  = state_r;
    tbl_re     = 1'b0;
    tbl_ra     = tidx_r;
    ring_re    = 1'b0;
    ring_ra    = slot_r;
    ring_we    = 1'b0;
    mul_ctl.en = 1'b0;
    mul_ctl.op = MUL_INTERP;
    case (state_r)
      S_IDLE: begin
        if (acc_tick) begin
          ring_re   = 1'b1;
          ring_ra   = rd_pos_r;
          state_nxt = S_TICK_OUT;
        end else if (acc_insert && phase_ok) begin
          state_nxt = S_T0;
        end
      end
      S_TICK_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_T0: begin
        tbl_re    = 1'b1;
        ring_re   = 1'b1;
        state_nxt = S_T1;
      end
      S_T1: begin
        tbl_re    = 1'b1;
        tbl_ra    = tidx_r + 1'b1;
        state_nxt = S_MF;
      end
      S_MF: begin
        mul_ctl.en = 1'b1;
        mul_ctl.op = MUL_INTERP;
        state_nxt  = S_MA;
      end
      S_MA: begin
        mul_ctl.en = 1'b1;
        mul_ctl.op = MUL_SCALE;
        state_nxt  = S_AC;
      end
      S_AC: begin
        ring_we = 1'b1;
        if (walk_last) begin
          state_nxt = S_IDLE;
        end else begin
          // The next slot's reads overlap this slot's write-back.
          tbl_re    = 1'b1;
          tbl_ra    = tidx_r + TW'(OVERSAMPLE);
          ring_re   = 1'b1;
          ring_ra   = slot_nxt;
          state_nxt = S_T1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Step table: one write port for loads, one registered read port.
  always_ff @(posedge clk) begin
    if (acc_load && (32'(in_ch.table_index) < TABLE_LEN)) begin
      tbl_mem[TW'(in_ch.table_index)] <= in_ch.table_word;
    end
    if (tbl_re) begin
      tbl_q <= tbl_mem[tbl_ra];
    end
  end

  // Correction ring: registered read, write-back of the accumulated slot.
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[slot_r] <= acc_sat;
    end
    if (ring_re) begin
      ring_q <= ring_mem[ring_ra];
    end
  end

  // Slot valid flags; a cleared flag makes the slot read as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_vld_r <= '0;
      ring_vq    <= 1'b0;
    end else begin
      if (ring_re) begin
        ring_vq <= ring_vld_r[ring_ra];
      end
      if (acc_tick) begin
        ring_vld_r[rd_pos_r] <= 1'b0;
      end else if (ring_we) begin
        ring_vld_r[slot_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pos_r <= '0;
    end else if (acc_tick) begin
      rd_pos_r <= (rd_pos_r == RW'(RING_LEN - 1)) ? '0 : rd_pos_r + 1'b1;
    end
  end

  // Walk state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (acc_insert) begin
      cnt_r <= '0;
    end else if (state_r == S_AC) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_insert) begin
      tidx_r <= TW'(phase_x[XW-1:FRAC_W]);
      frac_r <= phase_x[FRAC_W-1:0];
      amp_r  <= in_ch.amp;
      slot_r <= rd_pos_r;
    end else if (state_r == S_AC) begin
      tidx_r <= tidx_r + TW'(OVERSAMPLE);
      slot_r <= slot_nxt;
    end
    if (state_r == S_T1) begin
      t0_r <= tbl_q;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_TICK_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_TICK_OUT && out_free) begin
      out_sample_r <= ring_cur;
    end
  end

  // The walk must end on the slot just before the read position.
  a_walk_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_AC && walk_last) |-> (slot_nxt == rd_pos_r))
    else $error("insert walk did not cover the ring exactly once");

  // Both table reads of a walk step stay inside the table.
  a_tidx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_T0 || state_r == S_T1) |-> (32'(tidx_r) + 1 < TABLE_LEN))
    else $error("table index of walk out of range");

  // A tick leaves the slot it read empty until a later insert.
  a_tick_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TICK_OUT && $past(state_r) == S_IDLE) |-> !ring_vld_r[$past(rd_pos_r)])
    else $error("ticked slot still marked valid");

  // A tick result is only produced when the output register can take it.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TICK_OUT && out_valid_r && !out_ch.ready) |=> (state_r == S_TICK_OUT))
    else $error("tick left while output register was stalled");

endmodule

`default_nettype wire

// ===== design/mra_mul_unit.sv =====
// Shared multiplier of the ring accumulator. It forms either the table
// slope times the sub-sample fraction or the interpolated value times the
// amplitude, and registers the product. Depends on mra_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mra_mul_unit (
  input  logic                               clk,
  input  mra_pkg::mul_ctl_t                  ctl,
  input  logic signed [mra_pkg::DIFF_W-1:0]  diff,
  input  logic [mra_pkg::FRAC_W-1:0]         frac,
  input  logic signed [mra_pkg::TWORD_W-1:0] interp,
  input  logic signed [mra_pkg::AMP_W-1:0]   amp,
  output logic signed [mra_pkg::PROD_W-1:0]  prod_r
);
  import mra_pkg::*;

  logic signed [DIFF_W-1:0] op_a;
  logic signed [FRAC_W:0]   op_b;

  always_comb begin
    case (ctl.op)
      MUL_INTERP: begin
        op_a = diff;
        op_b = $signed({1'b0, frac});
      end
      MUL_SCALE: begin
        op_a = DIFF_W'(interp);
        op_b = (FRAC_W + 1)'(amp);
      end
      default: begin
        op_a = diff;
        op_b = $signed({1'b0, frac});
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      prod_r <= PROD_W'(op_a * op_b);
    end
  end

endmodule

`default_nettype wire
